### hw/rtl/project_points_pick_farthest_assert.svh
// Assertion macros for the point projector.
// Expects clk and rst_n in the scope of the use.
`ifndef PROJECT_POINTS_PICK_FARTHEST_ASSERT_SVH
`define PROJECT_POINTS_PICK_FARTHEST_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PPPF_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PPPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pppf_pkg.sv
// Widths, codes and saturation helper for the point projector.
// No dependencies.
`default_nettype none

package pppf_pkg;

    localparam int FIELD_W     = 32;
    localparam int COORD_WIDTH = 32;
    localparam int VEC_W       = (COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W;
    localparam int COEF_W      = 32;
    localparam int CIDX_W      = 5;
    localparam int COEF_DEPTH  = 1 << CIDX_W;
    localparam int DIGIT_W     = 8;
    localparam int NUM_DIGITS  = VEC_W / DIGIT_W;
    localparam int DCNT_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int FRAC_BITS   = 16;
    localparam int PP_W        = COEF_W + DIGIT_W + 1;
    localparam int PROD_W      = COEF_W + VEC_W;
    localparam int TERM_W      = PROD_W - FRAC_BITS;
    localparam int SUM_W       = TERM_W + 2;
    localparam int LIM_W       = COORD_WIDTH + 5;
    localparam int QUOT_W      = FRAC_BITS + 1;
    localparam int QCNT_W      = $clog2(QUOT_W);
    localparam int SCREEN_W    = 19;
    localparam int DIST_W      = 31;

    localparam int    DEPTH_MIN = 3277;  // 0.05 in Q16.16
    localparam int    W_MIN     = 7;     // 0.0001 in Q16.16
    localparam int    ONE_Q     = 65536;
    localparam longint DIST_MAX = (64'sd1 <<< DIST_W) - 1;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_POINT = 1'b1
    } opcode_t;

    typedef enum logic {
        PH_EYE  = 1'b0,
        PH_CLIP = 1'b1
    } phase_t;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_W = 2'd3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return hi[COORD_WIDTH-1:0];
        else if (v < lo)
            return lo[COORD_WIDTH-1:0];
        else
            return v[COORD_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/project_points_pick_farthest.sv
// Point projector that keeps the farthest visible point of a frame.
// Depends on pppf_pkg and project_points_pick_farthest_assert.svh.
// Usage:
//   Input channel (in_valid/in_ready) takes load requests (opcode 0) that
//   write one of 32 matrix coefficients, and point requests (opcode 1).
//   A load marked last arms the matrices; any other load disarms them.
//   A point marked last closes the frame and produces one result request on
//   out_valid/out_ready: found, distance, focus_u, focus_v (all zero when no
//   point of the frame was visible).
// Processing:
//   A load is taken in the idle state. A point does no arithmetic while the
//   matrices are not armed; otherwise 28 coefficient products run through one
//   32x8 digit-serial multiplier, one 8-bit digit per step and then an
//   accumulate step each. A new farthest point adds two 17-step restoring
//   divisions; a frame-closing point then emits. Until the point is done, in_ready stays low.
// Reset: clears the armed flag, the running best and the output register;
//   matrix coefficients stay undefined until loaded.
// Stall: the output register holds its result while out_ready is low; new
//   requests are still accepted, and only a later frame-closing point waits
//   for the output register to free up.
`default_nettype none

module project_points_pick_farthest
    import pppf_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic [CIDX_W-1:0]           coef_index,
    input  logic signed [COEF_W-1:0]    coef_value,
    input  logic signed [FIELD_W-1:0]   point_x,
    input  logic signed [FIELD_W-1:0]   point_y,
    input  logic signed [FIELD_W-1:0]   point_z,
    input  logic signed [FIELD_W-1:0]   height_offset,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        found,
    output logic [DIST_W-1:0]           distance,
    output logic signed [SCREEN_W-1:0]  focus_u,
    output logic signed [SCREEN_W-1:0]  focus_v
);

`include "project_points_pick_farthest_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MUL,
        ST_ACC,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef enum logic {
        DIV_U = 1'b0,
        DIV_V = 1'b1
    } div_sel_t;

    // control
    state_t                     state_reg, state_next;
    phase_t                     phase_reg, phase_next;
    logic [1:0]                 row_reg, row_next;
    logic [1:0]                 term_reg, term_next;
    logic [DCNT_W-1:0]          digit_cnt_reg, digit_cnt_next;
    logic [QCNT_W-1:0]          div_cnt_reg, div_cnt_next;
    div_sel_t                   div_sel_reg, div_sel_next;
    logic                       last_reg, last_next;
    logic                       armed_reg, armed_next;
    logic                       best_found_reg, best_found_next;
    logic [DIST_W-1:0]          best_dist_reg, best_dist_next;
    logic signed [SCREEN_W-1:0] best_u_reg, best_u_next;
    logic signed [SCREEN_W-1:0] best_v_reg, best_v_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       found_reg, found_next;
    logic [DIST_W-1:0]          distance_reg, distance_next;
    logic signed [SCREEN_W-1:0] focus_u_reg, focus_u_next;
    logic signed [SCREEN_W-1:0] focus_v_reg, focus_v_next;

    // datapath
    logic signed [COEF_W-1:0]   coef_mem [0:COEF_DEPTH-1];
    logic signed [COEF_W-1:0]   rd_data_reg;
    logic signed [VEC_W-1:0]    x_reg, y_reg;
    coord_t                     z_reg;
    coord_t                     e_reg [0:3];
    coord_t                     cx_reg, cy_reg, cw_reg;
    logic [VEC_W-1:0]           b_sh_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [DIST_W-1:0]          cand_dist_reg;
    logic signed [SCREEN_W-1:0] cand_u_reg;
    logic [COORD_WIDTH-1:0]     div_rem_reg;
    logic [QUOT_W-1:0]          div_q_reg;
    logic [QUOT_W-1:0]          div_bits_reg;
    logic                       div_neg_reg;

    logic                       in_acc, out_acc, emit_go;
    logic                       seq_done, last_term, last_digit, last_qbit;
    phase_t                     nxt_phase, sel_phase;
    logic [1:0]                 nxt_row, nxt_term, sel_row, sel_term;
    logic [CIDX_W-1:0]          rd_addr;
    logic signed [VEC_W-1:0]    vec_sel;
    logic [DIGIT_W-1:0]         digit;
    logic signed [DIGIT_W:0]    digit_s;
    logic signed [PP_W-1:0]     pp;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [TERM_W-1:0]   term_q;
    logic signed [SUM_W-1:0]    sum_acc;
    coord_t                     row_val;
    coord_t                     depth;
    logic signed [SUM_W-1:0]    depth_ext;
    logic [DIST_W-1:0]          d31;
    logic [COORD_WIDTH-1:0]     mag_x, mag_y, w_mag;
    logic [LIM_W-1:0]           lim_x, lim_y, lim_w;
    logic                       keep, better;
    logic [COORD_WIDTH:0]       div_r2, div_w, div_diff;
    logic                       div_ge;
    logic [QUOT_W-1:0]          q_full;
    logic signed [SCREEN_W-1:0] ndc, screen;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid_reg && out_ready;
    assign emit_go   = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign distance  = distance_reg;
    assign focus_u   = focus_u_reg;
    assign focus_v   = focus_v_reg;

    // ---------------- product sequencing ----------------
    assign last_term  = (term_reg == AXIS_W);
    assign last_digit = (digit_cnt_reg == DCNT_W'(NUM_DIGITS - 1));
    assign last_qbit  = (div_cnt_reg == QCNT_W'(QUOT_W - 1));

    // eye space: four rows; clip space: rows x, y and w only
    always_comb
    begin
        nxt_phase = phase_reg;
        nxt_row   = row_reg;
        nxt_term  = term_reg + 2'd1;
        seq_done  = 1'b0;
        if (last_term)
        begin
            nxt_term = AXIS_X;
            if (phase_reg == PH_EYE)
            begin
                if (row_reg == AXIS_W)
                begin
                    nxt_phase = PH_CLIP;
                    nxt_row   = AXIS_X;
                end
                else
                begin
                    nxt_row = row_reg + 2'd1;
                end
            end
            else
            begin
                unique case (row_reg)
                    AXIS_X:  nxt_row = AXIS_Y;
                    AXIS_Y:  nxt_row = AXIS_W;
                    default: seq_done = 1'b1;
                endcase
            end
        end
    end

    // the accumulate cycle already fetches for the next product
    assign sel_phase = (state_reg == ST_ACC) ? nxt_phase : phase_reg;
    assign sel_row   = (state_reg == ST_ACC) ? nxt_row   : row_reg;
    assign sel_term  = (state_reg == ST_ACC) ? nxt_term  : term_reg;
    assign rd_addr   = {sel_phase, sel_term, sel_row};  // column-major

    always_comb
    begin
        if (sel_phase == PH_EYE)
        begin
            unique case (sel_term)
                AXIS_X:  vec_sel = x_reg;
                AXIS_Y:  vec_sel = y_reg;
                AXIS_Z:  vec_sel = VEC_W'(z_reg);
                default: vec_sel = VEC_W'(ONE_Q);
            endcase
        end
        else
        begin
            vec_sel = VEC_W'(e_reg[sel_term]);
        end
    end

    // MSB digit first (signed), Horner accumulation
    assign digit     = b_sh_reg[VEC_W-1 -: DIGIT_W];
    assign digit_s   = (digit_cnt_reg == '0) ? $signed({digit[DIGIT_W-1], digit})
                                             : $signed({1'b0, digit});
    assign pp        = rd_data_reg * digit_s;
    assign prod_next = (prod_reg <<< DIGIT_W) + PROD_W'(pp);
    assign term_q    = prod_reg[PROD_W-1:FRAC_BITS];  // floor of product / 2^16
    assign sum_acc   = sum_reg + SUM_W'(term_q);
    assign row_val   = sat_coord(sum_acc);

    // ---------------- visibility test ----------------
    assign depth     = sat_coord(-SUM_W'(e_reg[AXIS_Z]));
    assign depth_ext = SUM_W'(depth);
    assign d31       = (depth_ext > SUM_W'(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                      : depth_ext[DIST_W-1:0];
    assign mag_x     = cx_reg[COORD_WIDTH-1] ? COORD_WIDTH'(-cx_reg) : COORD_WIDTH'(cx_reg);
    assign mag_y     = cy_reg[COORD_WIDTH-1] ? COORD_WIDTH'(-cy_reg) : COORD_WIDTH'(cy_reg);
    assign w_mag     = COORD_WIDTH'(cw_reg);
    // |ndc| <= 1.15 as 20*|c| <= 23*w
    assign lim_x     = (LIM_W'(mag_x) << 4) + (LIM_W'(mag_x) << 2);
    assign lim_y     = (LIM_W'(mag_y) << 4) + (LIM_W'(mag_y) << 2);
    assign lim_w     = (LIM_W'(w_mag) << 4) + (LIM_W'(w_mag) << 2)
                     + (LIM_W'(w_mag) << 1) + LIM_W'(w_mag);
    assign keep      = (depth >= coord_t'(DEPTH_MIN)) && (cw_reg >= coord_t'(W_MIN))
                     && (lim_x <= lim_w) && (lim_y <= lim_w);
    assign better    = !best_found_reg || (d31 > best_dist_reg);

    // ---------------- restoring divider, one quotient bit per cycle ----------------
    assign div_r2   = {div_rem_reg, div_bits_reg[QUOT_W-1]};
    assign div_w    = {1'b0, w_mag};
    assign div_diff = div_r2 - div_w;
    assign div_ge   = (div_r2 >= div_w);
    assign q_full   = {div_q_reg[QUOT_W-2:0], div_ge};
    assign ndc      = div_neg_reg ? -$signed(SCREEN_W'(q_full)) : $signed(SCREEN_W'(q_full));
    assign screen   = (ndc + SCREEN_W'(ONE_Q)) >>> 1;

    // ---------------- control ----------------
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        row_next        = row_reg;
        term_next       = term_reg;
        digit_cnt_next  = digit_cnt_reg;
        div_cnt_next    = div_cnt_reg;
        div_sel_next    = div_sel_reg;
        last_next       = last_reg;
        armed_next      = armed_reg;
        best_found_next = best_found_reg;
        best_dist_next  = best_dist_reg;
        best_u_next     = best_u_reg;
        best_v_next     = best_v_reg;
        out_valid_next  = out_valid_reg;
        found_next      = found_reg;
        distance_next   = distance_reg;
        focus_u_next    = focus_u_reg;
        focus_v_next    = focus_v_reg;

        if (out_acc)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (opcode == OP_LOAD)
                    begin
                        armed_next = last;
                    end
                    else
                    begin
                        last_next = last;
                        if (armed_reg)
                        begin
                            state_next = ST_START;
                            phase_next = PH_EYE;
                            row_next   = AXIS_X;
                            term_next  = AXIS_X;
                        end
                        else if (last)
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_START:
            begin
                digit_cnt_next = '0;
                state_next     = ST_MUL;
            end
            ST_MUL:
            begin
                digit_cnt_next = digit_cnt_reg + 1'b1;
                if (last_digit)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                digit_cnt_next = '0;
                phase_next     = nxt_phase;
                row_next       = nxt_row;
                term_next      = nxt_term;
                state_next     = seq_done ? ST_CHECK : ST_MUL;
            end
            ST_CHECK:
            begin
                div_cnt_next = '0;
                div_sel_next = DIV_U;
                if (keep && better)
                    state_next = ST_DIV;
                else
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (last_qbit)
                begin
                    div_cnt_next = '0;
                    if (div_sel_reg == DIV_U)
                    begin
                        div_sel_next = DIV_V;
                    end
                    else
                    begin
                        best_found_next = 1'b1;
                        best_dist_next  = cand_dist_reg;
                        best_u_next     = cand_u_reg;
                        best_v_next     = screen;
                        state_next      = last_reg ? ST_EMIT : ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next  = 1'b1;
                    found_next      = best_found_reg;
                    distance_next   = best_dist_reg;
                    focus_u_next    = best_u_reg;
                    focus_v_next    = best_v_reg;
                    best_found_next = 1'b0;
                    best_dist_next  = '0;
                    best_u_next     = '0;
                    best_v_next     = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_EYE;
            row_reg        <= AXIS_X;
            term_reg       <= AXIS_X;
            digit_cnt_reg  <= '0;
            div_cnt_reg    <= '0;
            div_sel_reg    <= DIV_U;
            last_reg       <= 1'b0;
            armed_reg      <= 1'b0;
            best_found_reg <= 1'b0;
            best_dist_reg  <= '0;
            best_u_reg     <= '0;
            best_v_reg     <= '0;
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            distance_reg   <= '0;
            focus_u_reg    <= '0;
            focus_v_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            row_reg        <= row_next;
            term_reg       <= term_next;
            digit_cnt_reg  <= digit_cnt_next;
            div_cnt_reg    <= div_cnt_next;
            div_sel_reg    <= div_sel_next;
            last_reg       <= last_next;
            armed_reg      <= armed_next;
            best_found_reg <= best_found_next;
            best_dist_reg  <= best_dist_next;
            best_u_reg     <= best_u_next;
            best_v_reg     <= best_v_next;
            out_valid_reg  <= out_valid_next;
            found_reg      <= found_next;
            distance_reg   <= distance_next;
            focus_u_reg    <= focus_u_next;
            focus_v_reg    <= focus_v_next;
        end
    end

    // ---------------- coefficient memory ----------------
    always_ff @(posedge clk)
    begin
        if (in_acc && (opcode == OP_LOAD))
            coef_mem[coef_index] <= coef_value;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= coef_mem[rd_addr];
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_acc && (opcode == OP_POINT))
        begin
            x_reg <= VEC_W'(point_x);
            y_reg <= VEC_W'(point_y);
            z_reg <= sat_coord(SUM_W'(point_z) + SUM_W'(height_offset));
        end

        unique case (state_reg)
            ST_START:
            begin
                b_sh_reg <= vec_sel;
                prod_reg <= '0;
                sum_reg  <= '0;
            end
            ST_MUL:
            begin
                prod_reg <= prod_next;
                b_sh_reg <= b_sh_reg << DIGIT_W;
            end
            ST_ACC:
            begin
                prod_reg <= '0;
                b_sh_reg <= vec_sel;
                if (last_term)
                begin
                    sum_reg <= '0;
                    if (phase_reg == PH_EYE)
                    begin
                        e_reg[row_reg] <= row_val;
                    end
                    else
                    begin
                        unique case (row_reg)
                            AXIS_X:  cx_reg <= row_val;
                            AXIS_Y:  cy_reg <= row_val;
                            default: cw_reg <= row_val;
                        endcase
                    end
                end
                else
                begin
                    sum_reg <= sum_acc;
                end
            end
            ST_CHECK:
            begin
                cand_dist_reg <= d31;
                // mag <= 1.15*w whenever the division runs, so mag/2 already sits below the divisor
                div_rem_reg   <= mag_x >> 1;
                div_bits_reg  <= {mag_x[0], {FRAC_BITS{1'b0}}};
                div_q_reg     <= '0;
                div_neg_reg   <= cx_reg[COORD_WIDTH-1];
            end
            ST_DIV:
            begin
                if (last_qbit && (div_sel_reg == DIV_U))
                begin
                    cand_u_reg   <= screen;
                    div_rem_reg  <= mag_y >> 1;
                    div_bits_reg <= {mag_y[0], {FRAC_BITS{1'b0}}};
                    div_q_reg    <= '0;
                    div_neg_reg  <= cy_reg[COORD_WIDTH-1];
                end
                else
                begin
                    div_rem_reg  <= div_ge ? div_diff[COORD_WIDTH-1:0]
                                           : div_r2[COORD_WIDTH-1:0];
                    div_bits_reg <= div_bits_reg << 1;
                    div_q_reg    <= q_full;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- assertions ----------------
    `PPPF_ASSERT_HOLDS(a_div_rem_below_w, state_reg == ST_DIV, div_rem_reg < w_mag, "divider remainder reached divisor")
    `PPPF_ASSERT_HOLDS(a_empty_result_zero, out_valid_reg && !found_reg, distance_reg == '0 && focus_u_reg == '0 && focus_v_reg == '0, "empty result carries nonzero fields")
    `PPPF_ASSERT_NEXT(a_best_cleared_on_emit, state_reg == ST_EMIT && emit_go, !best_found_reg && best_dist_reg == '0 && out_valid_reg, "running best not cleared on emit")
    `PPPF_ASSERT_HOLDS(a_best_depth_floor, best_found_reg, best_dist_reg >= DIST_W'(DEPTH_MIN), "kept point below depth limit")

endmodule

`default_nettype wire
